@@ src/gdu_pkg.sv @@
`timescale 1ns / 1ps

package gdu_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int XW            = $clog2(SCREEN_WIDTH);
    localparam int PW            = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int RW            = PW + 3;
    localparam int CW            = 12;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_PIXEL  = 3'd1;
    localparam logic [2:0] CMD_INVERT = 3'd2;
    localparam logic [2:0] CMD_SMALL  = 3'd3;
    localparam logic [2:0] CMD_BIG    = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    typedef enum logic [1:0] {K_NONE, K_CLEAR, K_DRAW, K_READ} kind_t;
    typedef enum logic [1:0] {OP_SET, OP_XOR, OP_GLYPH} op_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic signed [8:0] pos_x;
        logic signed [7:0] pos_y;
        logic [7:0]        rect_width;
        logic [6:0]        rect_height;
        logic [7:0]        char_code;
        logic              pixel_on;
        logic [9:0]        byte_index;
    } item_t;

    typedef struct packed {
        kind_t                kind;
        op_t                  op;
        logic                 empty;
        logic [XW-1:0]        cx0;
        logic [XW-1:0]        cx1;
        logic [RW-1:0]        ry0;
        logic [RW-1:0]        ry1;
        logic [PW-1:0]        pg0;
        logic [PW-1:0]        pg1;
        logic                 value;
        logic signed [CW-1:0] org_x;
        logic signed [CW-1:0] org_y;
        logic                 big;
        logic [3:0]           glyph;
        logic                 read_ok;
        logic [ADDR_W-1:0]    read_addr;
    } geom_t;

    function automatic logic [3:0] glyph_index(input logic [7:0] code);
        logic [3:0] idx;
        idx = 4'd0;
        if (code == 8'h2D) idx = 4'd1;
        else if (code == 8'h3A) idx = 4'd2;
        else if (code >= 8'h30 && code <= 8'h39) idx = 4'(code - 8'h30) + 4'd3;
        return idx;
    endfunction

    // Column 0 sits in the lowest byte; bit r of a column is row r.
    function automatic logic [63:0] glyph_bits(input logic [3:0] idx);
        logic [63:0] g;
        unique case (idx)
            4'd1:    g = 64'h0000_0000_0808_0000;
            4'd2:    g = 64'h0000_0000_3636_0000;
            4'd3:    g = 64'h0000_003E_4549_513E;
            4'd4:    g = 64'h0000_0000_407F_4200;
            4'd5:    g = 64'h0000_0046_4949_5162;
            4'd6:    g = 64'h0000_0036_4949_4922;
            4'd7:    g = 64'h0000_0010_7F12_1418;
            4'd8:    g = 64'h0000_0031_4949_492F;
            4'd9:    g = 64'h0000_0032_4949_493E;
            4'd10:   g = 64'h0000_0003_0509_7101;
            4'd11:   g = 64'h0000_0036_4949_4936;
            4'd12:   g = 64'h0000_003E_4949_4926;
            default: g = 64'h0;
        endcase
        return g;
    endfunction

endpackage

@@ src/page_framebuffer_glyph_draw_unit.sv @@
`timescale 1ns / 1ps
// A drawing item is done with one read-modify-write of a framebuffer byte per cycle through
// the RAM port pair, over the clipped columns of each page in turn. A clear sweeps zeros
// through all STORE_BYTES bytes; an unknown or fully clipped item goes straight to S_DONE.
// One item at a time; s_tready rises together with m_tvalid, later while a
// result waits. After reset the sequencer sweeps zeros through all STORE_BYTES (1024)
// bytes before the first item is accepted.

module page_framebuffer_glyph_draw_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // pos_x, pos_y, rect_width, rect_height, char_code,
                                  // pixel_on, byte_index, zero fill
    input  logic [2:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data, done_res, zero fill
);
    import gdu_pkg::*;

    typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_SETUP, S_RUN, S_DRAIN, S_READ, S_DONE}
        state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              sweep_cmd_reg, sweep_cmd_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [PW-1:0]     page_reg, page_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [XW-1:0]     p1_x_reg;
    logic [PW-1:0]     p1_page_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [7:0]        res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;

    item_t             item;
    geom_t             geom;
    logic              accept;
    logic [ADDR_W-1:0] cur_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata, new_byte;

    assign item.cmd         = s_tuser;
    assign item.pos_x       = s_tdata[8:0];
    assign item.pos_y       = s_tdata[16:9];
    assign item.rect_width  = s_tdata[24:17];
    assign item.rect_height = s_tdata[31:25];
    assign item.char_code   = s_tdata[39:32];
    assign item.pixel_on    = s_tdata[40];
    assign item.byte_index  = s_tdata[50:41];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, 1'b1, out_data_reg};

    assign cur_addr  = ADDR_W'(int'(page_reg) * SCREEN_WIDTH + int'(x_reg));
    assign ram_raddr = (state_reg == S_SETUP) ? geom.read_addr : cur_addr;
    assign ram_we    = (state_reg == S_SWEEP) || p1_valid_reg;
    assign ram_waddr = (state_reg == S_SWEEP) ? sweep_reg : p1_addr_reg;
    assign ram_wdata = (state_reg == S_SWEEP) ? 8'd0 : new_byte;

    gdu_setup u_setup (
        .clk  (clk),
        .load (accept),
        .item (item),
        .geom (geom)
    );

    gdu_byte_unit u_byte (
        .geom     (geom),
        .x        (p1_x_reg),
        .page     (p1_page_reg),
        .old_byte (ram_rdata),
        .new_byte (new_byte)
    );

    gdu_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        sweep_cmd_next = sweep_cmd_reg;
        x_next         = x_reg;
        page_next      = page_reg;
        p1_valid_next  = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = sweep_cmd_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                res_next = 8'd0;
                unique case (geom.kind)
                    K_CLEAR:
                    begin
                        sweep_next     = '0;
                        sweep_cmd_next = 1'b1;
                        state_next     = S_SWEEP;
                    end
                    K_READ:  state_next = geom.read_ok ? S_READ : S_DONE;
                    K_DRAW:
                    begin
                        x_next     = geom.cx0;
                        page_next  = geom.pg0;
                        state_next = geom.empty ? S_DONE : S_RUN;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RUN:
            begin
                p1_valid_next = 1'b1;
                if (x_reg == geom.cx1)
                begin
                    x_next = geom.cx0;
                    if (page_reg == geom.pg1)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        page_next = page_reg + PW'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
            end
            S_DRAIN: state_next = S_DONE;
            S_READ:
            begin
                res_next   = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            sweep_cmd_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            sweep_cmd_reg <= sweep_cmd_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        page_reg     <= page_next;
        p1_x_reg     <= x_reg;
        p1_page_reg  <= page_reg;
        p1_addr_reg  <= cur_addr;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !ram_we)
        else $error("framebuffer written while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (x_reg >= geom.cx0 && x_reg <= geom.cx1 &&
                                  page_reg >= geom.pg0 && page_reg <= geom.pg1))
        else $error("draw position outside clipped region");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < STORE_BYTES))
        else $error("write address beyond store");

    assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> $past(state_reg == S_RUN))
        else $error("write-back without a preceding read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("result not delivered to output register");
`endif

endmodule

@@ src/gdu_ram.sv @@
`timescale 1ns / 1ps

module gdu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/gdu_setup.sv @@
`timescale 1ns / 1ps

module gdu_setup (
    input  logic           clk,
    input  logic           load,
    input  gdu_pkg::item_t item,
    output gdu_pkg::geom_t geom
);
    import gdu_pkg::*;

    localparam logic signed [CW-1:0] XMAX = CW'(SCREEN_WIDTH - 1);
    localparam logic signed [CW-1:0] YMAX = CW'(SCREEN_HEIGHT - 1);
    localparam logic signed [CW-1:0] ZERO = CW'(0);

    logic signed [CW-1:0] xs, ys, xe, ye, xlo, xhi, ylo, yhi;
    geom_t geom_next;

    always_comb
    begin
        xs = CW'(item.pos_x);
        ys = CW'(item.pos_y);
        xe = xs;
        ye = ys;
        geom_next.kind = K_NONE;
        geom_next.op   = OP_SET;
        unique case (item.cmd)
            CMD_CLEAR:  geom_next.kind = K_CLEAR;
            CMD_PIXEL:  geom_next.kind = K_DRAW;
            CMD_INVERT:
            begin
                geom_next.kind = K_DRAW;
                geom_next.op   = OP_XOR;
                xe = xs + signed'(CW'(item.rect_width)) - CW'(1);
                ye = ys + signed'(CW'(item.rect_height)) - CW'(1);
            end
            CMD_SMALL:
            begin
                geom_next.kind = K_DRAW;
                geom_next.op   = OP_GLYPH;
                xe = xs + CW'(5);
                ye = ys + CW'(7);
            end
            CMD_BIG:
            begin
                geom_next.kind = K_DRAW;
                geom_next.op   = OP_GLYPH;
                xe = xs + CW'(11);
                ye = ys + CW'(15);
            end
            CMD_READ:   geom_next.kind = K_READ;
            default:    geom_next.kind = K_NONE;
        endcase

        xlo = (xs < ZERO) ? ZERO : xs;
        xhi = (xe > XMAX) ? XMAX : xe;
        ylo = (ys < ZERO) ? ZERO : ys;
        yhi = (ye > YMAX) ? YMAX : ye;

        geom_next.empty = (xe < ZERO) || (xs > XMAX) || (ye < ZERO) || (ys > YMAX) ||
                          (item.cmd == CMD_INVERT &&
                           (item.rect_width == 8'd0 || item.rect_height == 7'd0));
        geom_next.cx0       = xlo[XW-1:0];
        geom_next.cx1       = xhi[XW-1:0];
        geom_next.ry0       = ylo[RW-1:0];
        geom_next.ry1       = yhi[RW-1:0];
        geom_next.pg0       = ylo[RW-1:3];
        geom_next.pg1       = yhi[RW-1:3];
        geom_next.value     = item.pixel_on;
        geom_next.org_x     = xs;
        geom_next.org_y     = ys;
        geom_next.big       = (item.cmd == CMD_BIG);
        geom_next.glyph     = glyph_index(item.char_code);
        geom_next.read_ok   = (32'(item.byte_index) < STORE_BYTES);
        geom_next.read_addr = ADDR_W'(item.byte_index);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            geom <= geom_next;
        end
    end

endmodule

@@ src/gdu_byte_unit.sv @@
`timescale 1ns / 1ps

module gdu_byte_unit (
    input  gdu_pkg::geom_t          geom,
    input  logic [gdu_pkg::XW-1:0]  x,
    input  logic [gdu_pkg::PW-1:0]  page,
    input  logic [7:0]              old_byte,
    output logic [7:0]              new_byte
);
    import gdu_pkg::*;

    logic [63:0]          gbits;
    logic signed [CW-1:0] dx;
    logic [2:0]           col;
    logic [7:0]           col_bits;
    logic [RW-1:0]        row [8];
    logic signed [CW-1:0] dy [8];
    logic [2:0]           grow [8];
    logic                 inrow [8];

    always_comb
    begin
        gbits    = glyph_bits(geom.glyph);
        dx       = CW'(x) - geom.org_x;
        col      = geom.big ? dx[3:1] : dx[2:0];
        col_bits = gbits[{col, 3'b000} +: 8];
        for (int b = 0; b < 8; b++)
        begin
            row[b]   = {page, 3'(b)};
            inrow[b] = (row[b] >= geom.ry0) && (row[b] <= geom.ry1);
            dy[b]    = CW'(row[b]) - geom.org_y;
            grow[b]  = geom.big ? dy[b][3:1] : dy[b][2:0];
            new_byte[b] = old_byte[b];
            if (inrow[b])
            begin
                unique case (geom.op)
                    OP_SET:   new_byte[b] = geom.value;
                    OP_XOR:   new_byte[b] = ~old_byte[b];
                    OP_GLYPH: new_byte[b] = col_bits[grow[b]];
                    default:  new_byte[b] = old_byte[b];
                endcase
            end
        end
    end

endmodule

@@ tb/sv/page_framebuffer_glyph_draw_unit_test.sv @@
`timescale 1ns / 1ps

module page_framebuffer_glyph_draw_unit_test;
    import gdu_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int HOLD_CYCLES = 600;

    // Column 0 in the lowest byte; bit r of a column is row r.
    localparam logic [47:0] FONT [13] = '{
        48'h0000_0000_0000,
        48'h0000_0808_0000,
        48'h0000_3636_0000,
        48'h003E_4549_513E,
        48'h0000_407F_4200,
        48'h0046_4949_5162,
        48'h0036_4949_4922,
        48'h0010_7F12_1418,
        48'h0031_4949_492F,
        48'h0032_4949_493E,
        48'h0003_0509_7101,
        48'h0036_4949_4936,
        48'h003E_4949_4926
    };

    typedef struct packed {
        logic [7:0] read_data;
        logic       done;
    } reply_t;

    class framebuffer_mirror;
        logic [7:0] bytes [STORE_BYTES];
        reply_t     expected_replies [$];
        int         errors;

        function new();
            foreach (bytes[i])
                bytes[i] = 8'h00;
            errors = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function int font_slot(logic [7:0] code);
            if (code == CHAR_DASH)
                return 1;
            if (code == CHAR_COLON)
                return 2;
            if (code >= CHAR_ZERO && code <= CHAR_NINE)
                return int'(code - CHAR_ZERO) + 3;
            return 0;
        endfunction

        function void touch_pixel(int x, int y, bit flip, bit value);
            int idx;
            if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
                return;
            idx = (y >> 3) * SCREEN_WIDTH + x;
            if (idx >= STORE_BYTES)
                return;
            if (flip)
                bytes[idx][y & 7] = ~bytes[idx][y & 7];
            else
                bytes[idx][y & 7] = value;
        endfunction

        function void draw_glyph(int x, int y, logic [7:0] code, int scale);
            logic [47:0] cols;
            logic [7:0]  column;
            cols = FONT[font_slot(code)];
            for (int c = 0; c < 6; c++)
            begin
                column = cols[c * 8 +: 8];
                for (int r = 0; r < 8; r++)
                    for (int dy = 0; dy < scale; dy++)
                        for (int dx = 0; dx < scale; dx++)
                            touch_pixel(x + c * scale + dx, y + r * scale + dy, 0,
                                        column[r]);
            end
        endfunction

        function void take_command(logic [2:0] op, logic [55:0] d);
            int         x;
            int         y;
            int         w;
            int         h;
            int         bi;
            reply_t     reply;
            x = int'($signed(d[8:0]));
            y = int'($signed(d[16:9]));
            w = int'(d[24:17]);
            h = int'(d[31:25]);
            bi = int'(d[50:41]);
            reply.read_data = 8'h00;
            reply.done = 1'b1;
            case (op)
                CMD_CLEAR:
                    foreach (bytes[i])
                        bytes[i] = 8'h00;
                CMD_PIXEL:
                    touch_pixel(x, y, 0, d[40]);
                CMD_INVERT:
                    for (int yy = y; yy < y + h; yy++)
                        for (int xx = x; xx < x + w; xx++)
                            touch_pixel(xx, yy, 1, 1'b0);
                CMD_SMALL:
                    draw_glyph(x, y, d[39:32], 1);
                CMD_BIG:
                    draw_glyph(x, y, d[39:32], 2);
                CMD_READ:
                    if (bi < STORE_BYTES)
                        reply.read_data = bytes[bi];
                default:
                    ;
            endcase
            expected_replies.push_back(reply);
        endfunction

        function void check_reply(logic [15:0] r);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual read_data %02h done %0b",
                         $time, r[7:0], r[8]);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            if (r[7:0] !== want.read_data)
            begin
                $display("%0t: read_data mismatch: expected %02h, actual %02h",
                         $time, want.read_data, r[7:0]);
                errors++;
            end
            if (r[8] !== want.done)
            begin
                $display("%0t: done_res mismatch: expected %0b, actual %0b",
                         $time, want.done, r[8]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    framebuffer_mirror mirror = new();
    int                items_sent;
    int                replies_seen;
    int                last_x;
    int                last_y;

    page_framebuffer_glyph_draw_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [55:0] pack_item(int x, int y, int w, int h, logic [7:0] code,
                                              logic value, int bi);
        return {5'b0, 10'(bi), value, code, 7'(h), 8'(w), 8'(y), 9'(x)};
    endfunction

    function automatic logic [7:0] pick_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 3)
            return 8'($urandom_range(0, 255));
        if (n == 3)
            return CHAR_SPACE;
        if (n == 4)
            return CHAR_DASH;
        if (n == 5)
            return CHAR_COLON;
        return CHAR_ZERO + 8'(n - 6);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [2:0] op, input logic [55:0] d);
        int gap;
        gap = ((items_sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser = op;
        s_tdata = d;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mirror.take_command(op, d);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int         n;
        int         x;
        int         y;
        int         w;
        int         h;
        int         bi;
        logic [2:0] op;
        n = $urandom_range(0, 99);
        if (n < 2)
            op = CMD_CLEAR;
        else if (n < 22)
            op = CMD_PIXEL;
        else if (n < 36)
            op = CMD_INVERT;
        else if (n < 51)
            op = CMD_SMALL;
        else if (n < 64)
            op = CMD_BIG;
        else if (n < 97)
            op = CMD_READ;
        else
            op = (n == 97) ? CMD_SPARE_A : CMD_SPARE_B;
        if ($urandom_range(0, 7) == 0)
        begin
            x = $urandom_range(0, 383) - 128;
            y = $urandom_range(0, 191) - 64;
        end
        else
        begin
            x = $urandom_range(0, 151) - 12;
            y = $urandom_range(0, 95) - 16;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            w = $urandom_range(0, 255);
            h = $urandom_range(0, 127);
        end
        else
        begin
            w = $urandom_range(0, 20);
            h = $urandom_range(0, 20);
        end
        if (op == CMD_READ && $urandom_range(0, 2) != 0)
        begin
            bi = (((last_y < 0) ? 0 : (last_y > 63) ? 63 : last_y) >> 3) + $urandom_range(0, 1);
            bi = (bi > 7) ? 7 : bi;
            x = last_x + $urandom_range(0, 12);
            bi = bi * SCREEN_WIDTH + ((x < 0) ? 0 : (x > 127) ? 127 : x);
        end
        else
            bi = $urandom_range(0, 1023);
        if (op != CMD_READ)
        begin
            last_x = x;
            last_y = y;
        end
        send_item(op, pack_item(x, y, w, h, pick_char(), 1'($urandom_range(0, 1)), bi));
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_CLEAR;
        rst_n = 1'b0;
        items_sent = 0;
        last_x = 0;
        last_y = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 1023));
        send_item(CMD_PIXEL, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b1, 0));
        send_item(CMD_PIXEL, pack_item(127, 63, 0, 0, CHAR_SPACE, 1'b1, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 1023));
        send_item(CMD_PIXEL, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 0));
        send_item(CMD_PIXEL, pack_item(-1, 0, 0, 0, CHAR_SPACE, 1'b1, 0));
        send_item(CMD_PIXEL, pack_item(128, 5, 0, 0, CHAR_SPACE, 1'b1, 0));
        send_item(CMD_PIXEL, pack_item(-128, -64, 0, 0, CHAR_SPACE, 1'b1, 0));
        send_item(CMD_PIXEL, pack_item(255, 127, 0, 0, CHAR_SPACE, 1'b1, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 0));
        send_item(CMD_SMALL, pack_item(0, 0, 0, 0, CHAR_ZERO, 1'b0, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 1));
        send_item(CMD_BIG, pack_item(122, 60, 0, 0, CHAR_NINE, 1'b0, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 7 * 128 + 125));
        send_item(CMD_SMALL, pack_item(-3, -4, 0, 0, 8'hFF, 1'b0, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 1));
        send_item(CMD_INVERT, pack_item(-128, -64, 255, 127, CHAR_SPACE, 1'b0, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 512));
        send_item(CMD_INVERT, pack_item(5, 5, 0, 10, CHAR_SPACE, 1'b0, 0));
        send_item(CMD_INVERT, pack_item(5, 5, 10, 0, CHAR_SPACE, 1'b0, 0));
        send_item(CMD_SPARE_A, pack_item(3, 3, 3, 3, CHAR_DASH, 1'b1, 3));
        send_item(CMD_SPARE_B, pack_item(4, 4, 4, 4, CHAR_COLON, 1'b1, 4));
        send_item(CMD_CLEAR, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 0));
        send_item(CMD_READ, pack_item(0, 0, 0, 0, CHAR_SPACE, 1'b0, 1023));

        repeat (580)
            send_random_item();
        s_tvalid = 1'b0;

        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mirror.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int gap;
        m_tready = 1'b0;
        replies_seen = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (replies_seen == 30 || replies_seen == 300)
                gap = HOLD_CYCLES;
            else if ((replies_seen / 64) % 3 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            mirror.check_reply(m_tdata);
            replies_seen++;
            @(negedge clk);
        end
    end

    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
src/gdu_pkg.sv
src/gdu_ram.sv
src/gdu_setup.sv
src/gdu_byte_unit.sv
src/page_framebuffer_glyph_draw_unit.sv
tb/sv/page_framebuffer_glyph_draw_unit_test.sv
